// ===== hw/rtl/bdac_pkg.sv =====
package bdac_pkg;

  localparam int VALUE_W      = 32;
  localparam int BCD_DIGITS   = 10;
  localparam int BCD_W        = 4 * BCD_DIGITS;
  localparam int FIXED_DIGITS = 4;
  localparam int DIGIT_IDX_W  = 4;
  localparam int CHAR_W       = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } out_item_t;

endpackage

// ===== hw/rtl/bdac_front.sv =====
module bdac_front import bdac_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_data,
  output logic     q_valid,
  output in_item_t q_item,
  input  logic     q_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  in_item_t entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic push_ok, pop_ok;

  assign in_full = (cnt_r == CNT_W'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = entries_r[rd_ptr_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

// ===== hw/rtl/bdac_back.sv =====
module bdac_back import bdac_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  in_item_t  q_item,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_FIND = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  localparam int CNT_W = $clog2(VALUE_W);

  state_t state_r, state_nxt;
  logic [VALUE_W-1:0]     bin_r, bin_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt, bcd_adj;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   kind_r, kind_nxt;
  logic [DIGIT_IDX_W-1:0] idx_r, idx_nxt, lead;
  logic [3:0]             nib;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;
  logic                   slot_free;

  // add-3 correction ahead of each shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                     : bcd_r[i*4 +: 4];
    end
  end

  // most significant non-zero digit, zero value gives digit 0
  always_comb begin
    lead = '0;
    for (int i = 1; i < BCD_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        lead = DIGIT_IDX_W'(i);
      end
    end
  end

  assign nib       = bcd_r[{idx_r, 2'b00} +: 4];
  assign slot_free = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_data  = out_item_r;

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_pop;
    q_pop         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          bin_nxt   = q_item.value;
          kind_nxt  = q_item.kind;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        {bcd_nxt, bin_nxt} = {bcd_adj[BCD_W-2:0], bin_r, 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VALUE_W - 1)) begin
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        idx_nxt   = kind_r ? DIGIT_IDX_W'(FIXED_DIGITS - 1) : lead;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.digit_char = ASCII_ZERO + {2'b00, nib};
          out_item_nxt.last       = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    kind_r     <= kind_nxt;
    idx_r      <= idx_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

// ===== hw/rtl/binary_to_decimal_ascii_unit.sv =====
// Each accepted item passes the 32-step shift-and-add-3 converter; its n = 1..10 digits then go out
// one digit per cycle into the output register, while that register is empty or being popped.
// The converter takes the next item only after the last digit of the previous one has gone out.
// The input queue takes further items while a conversion runs.
// Reset: synchronous, active low; empties both queues and returns the converter to idle.
module binary_to_decimal_ascii_unit import bdac_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic     q_valid;
  logic     q_pop;
  in_item_t q_item;

  bdac_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  bdac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/bdac_checker.sv =====
module bdac_checker import bdac_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_push,
  input logic      in_full,
  input in_item_t  in_data,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_no_item_early: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> out_empty)
    else $error("item shown straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting item changed");

  a_digit: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_data.digit_char >= ASCII_ZERO &&
                   out_data.digit_char <= ASCII_ZERO + 6'd9)
    else $error("digit out of range");

endmodule

bind binary_to_decimal_ascii_unit bdac_checker u_bdac_checker (.*);
